### hdl/windowed_trend_statistics_assert.svh
// Assertion macros shared by the windowed trend statistics RTL.
// Holds only macro definitions; each file that asserts includes it by name.
`ifndef WINDOWED_TREND_STATISTICS_ASSERT_SVH
`define WINDOWED_TREND_STATISTICS_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define WTS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("windowed trend statistics: assertion failed");

// Next-cycle implication, disabled while reset is low.
`define WTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("windowed trend statistics: assertion failed");

`endif

### hdl/wts_pkg.sv
// Package for the windowed trend statistics block: sequencer states,
// divider status type and fixed constants. No dependencies.
`default_nettype none

package wts_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_AVG,
    ST_AVG_W,
    ST_RNG,
    ST_ZDIV_W,
    ST_MAR,
    ST_MAR_W,
    ST_DONE
  } wts_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned BOUND_W  = 34;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned RANGE_W  = 33;
  localparam int unsigned DIV_TEN  = 10;
  localparam int unsigned ONE_Q16  = 65536;

endpackage

`default_nettype wire

### hdl/wts_store.sv
// Sample window memory: one write port and one registered read port.
// Depends on nothing outside this file.
`default_nettype none

module wts_store #(
  parameter int unsigned WINDOW_DEPTH = 256,
  parameter int unsigned DATA_W       = 32,
  localparam int unsigned ADDR_W      = $clog2(WINDOW_DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [DATA_W-1:0] wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output logic      [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem [WINDOW_DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### hdl/wts_divider.sv
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on wts_pkg for the status struct.
`default_nettype none

module wts_divider #(
  parameter int unsigned DIVIDEND_W = 41,
  parameter int unsigned DIVISOR_W  = 9
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DIVIDEND_W-1:0] dividend_i,
  input  wire logic [DIVISOR_W-1:0]  divisor_i,
  output logic      [DIVIDEND_W-1:0] quotient_o,
  output wts_pkg::div_status_t       status_o
);

  localparam int unsigned STEP_W = $clog2(DIVIDEND_W + 1);

  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  dsr_q, dsr_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [STEP_W-1:0]     cnt_q, cnt_d;
  logic                  done_q, done_d;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = (trial >= {1'b0, dsr_q});

  always_comb begin
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    done_d = done_q;
    if (start_i) begin
      rem_d  = '0;
      dsr_d  = divisor_i;
      quo_d  = dividend_i;
      cnt_d  = STEP_W'(DIVIDEND_W);
      done_d = 1'b0;
    end else if (cnt_q != '0) begin
      // A trial below the divisor always fits the remainder width.
      rem_d  = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_d  = {quo_q[DIVIDEND_W-2:0], ge};
      cnt_d  = cnt_q - STEP_W'(1);
      done_d = (cnt_q == STEP_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign quotient_o    = quo_q;
  assign status_o.busy = (cnt_q != '0);
  assign status_o.done = done_q;

endmodule

`default_nettype wire

### hdl/windowed_trend_statistics.sv
// Windowed trend statistics: each sample beat is stored in a circular window of
// WINDOW_DEPTH entries, then the n valid entries are rescanned through the memory
// read port (one per cycle) for minimum, maximum and sum, and one shared
// bit-serial divider forms the average (sum / n) and the display margin
// (range / 10, after |min| / 10 when the range is zero). The sum and the
// divider dividend are 33 + clog2(WINDOW_DEPTH) bits wide. The input is not
// ready while an item is worked on; a finished result sits in an output
// register, so the next sample beat is taken while it waits. The memory needs
// no clearing after reset.
`default_nettype none

module windowed_trend_statistics #(
  parameter int unsigned WINDOW_DEPTH = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] sample_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [31:0] window_min_o,
  output logic      [31:0] window_max_o,
  output logic      [33:0] lower_bound_o,
  output logic      [33:0] upper_bound_o,
  output logic      [31:0] window_average_o,
  output logic      [8:0]  sample_count_o
);

  localparam int unsigned ADDR_W = $clog2(WINDOW_DEPTH);
  localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SUM_W  = 33 + $clog2(WINDOW_DEPTH);
  localparam int unsigned DIV_W  = (CNT_W > 4) ? CNT_W : 4;
  localparam int unsigned SW     = wts_pkg::SAMPLE_W;
  localparam int unsigned RW     = wts_pkg::RANGE_W;
  localparam int unsigned BW     = wts_pkg::BOUND_W;

  wts_pkg::wts_state_e state_q, state_d;

  logic [ADDR_W-1:0] wr_idx_q, wr_idx_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [CNT_W-1:0]  iss_q, iss_d;
  logic              rd_vld_q;
  logic              first_q, first_d;
  logic              out_valid_q, out_valid_d;

  logic signed [SW-1:0]    lo_q, lo_d, hi_q, hi_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic signed [SW-1:0]    avg_q, avg_d;
  logic [RW-1:0]           range_q, range_d;
  logic [SW-1:0]           margin_q, margin_d;

  logic              accept;
  logic              rd_en;
  logic              scan_end;
  logic [SW-1:0]     rd_data;
  logic signed [SW-1:0] v;
  logic [RW-1:0]     diff_rng;
  logic [RW-1:0]     abs_lo;
  logic [SUM_W-1:0]  abs_sum;
  logic [SW-1:0]     quo_lo;
  logic              load_out;

  logic                 div_start;
  logic [SUM_W-1:0]     div_dividend;
  logic [DIV_W-1:0]     div_divisor;
  logic [SUM_W-1:0]     div_quo;
  wts_pkg::div_status_t div_status;

  logic [31:0] cnt_ext;

  assign accept = in_valid_i && in_ready_o;

  wts_store #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .DATA_W      (SW)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (accept),
    .wr_addr_i(wr_idx_q),
    .wr_data_i(sample_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(iss_q[ADDR_W-1:0]),
    .rd_data_o(rd_data)
  );

  wts_divider #(
    .DIVIDEND_W(SUM_W),
    .DIVISOR_W (DIV_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .quotient_o(div_quo),
    .status_o  (div_status)
  );

  // Arithmetic helpers shared by the sequencer states.
  assign v        = rd_data;
  assign diff_rng = RW'({hi_q[SW-1], hi_q} - {lo_q[SW-1], lo_q});
  assign abs_lo   = lo_q[SW-1] ? (RW'(0) - {lo_q[SW-1], lo_q}) : {lo_q[SW-1], lo_q};
  assign abs_sum  = sum_q[SUM_W-1] ? (SUM_W'(0) - sum_q) : sum_q;
  assign quo_lo   = div_quo[SW-1:0];

  assign rd_en    = (state_q == wts_pkg::ST_SCAN) && (iss_q < fill_q);
  assign scan_end = (state_q == wts_pkg::ST_SCAN) && !rd_en && !rd_vld_q;
  assign load_out = (state_q == wts_pkg::ST_DONE) && (!out_valid_q || out_ready_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      wts_pkg::ST_IDLE:   if (accept) state_d = wts_pkg::ST_SCAN;
      wts_pkg::ST_SCAN:   if (scan_end) state_d = wts_pkg::ST_AVG;
      wts_pkg::ST_AVG:    state_d = wts_pkg::ST_AVG_W;
      wts_pkg::ST_AVG_W:  if (div_status.done) state_d = wts_pkg::ST_RNG;
      wts_pkg::ST_RNG: begin
        if (diff_rng == '0) state_d = wts_pkg::ST_ZDIV_W;
        else                state_d = wts_pkg::ST_MAR;
      end
      wts_pkg::ST_ZDIV_W: if (div_status.done) state_d = wts_pkg::ST_MAR;
      wts_pkg::ST_MAR:    state_d = wts_pkg::ST_MAR_W;
      wts_pkg::ST_MAR_W:  if (div_status.done) state_d = wts_pkg::ST_DONE;
      wts_pkg::ST_DONE:   if (load_out) state_d = wts_pkg::ST_IDLE;
      default:            state_d = wts_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs and divider operand selection.
  always_comb begin
    in_ready_o   = 1'b0;
    div_start    = 1'b0;
    div_dividend = SUM_W'(range_q);
    div_divisor  = DIV_W'(wts_pkg::DIV_TEN);
    case (state_q)
      wts_pkg::ST_IDLE: in_ready_o = 1'b1;
      wts_pkg::ST_AVG: begin
        div_start    = 1'b1;
        div_dividend = abs_sum;
        div_divisor  = DIV_W'(fill_q);
      end
      wts_pkg::ST_RNG: begin
        div_start    = (diff_rng == '0);
        div_dividend = SUM_W'(abs_lo);
      end
      wts_pkg::ST_MAR: div_start = 1'b1;
      default: begin
        in_ready_o = 1'b0;
        div_start  = 1'b0;
      end
    endcase
  end

  // Window bookkeeping, scan accumulation and result arithmetic.
  always_comb begin
    wr_idx_d    = wr_idx_q;
    fill_d      = fill_q;
    iss_d       = iss_q;
    first_d     = first_q;
    out_valid_d = out_valid_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    sum_d       = sum_q;
    avg_d       = avg_q;
    range_d     = range_q;
    margin_d    = margin_q;

    if (accept) begin
      wr_idx_d = (wr_idx_q == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : wr_idx_q + ADDR_W'(1);
      if (fill_q != CNT_W'(WINDOW_DEPTH)) begin
        fill_d = fill_q + CNT_W'(1);
      end
      iss_d   = '0;
      first_d = 1'b1;
    end

    if (rd_en) begin
      iss_d = iss_q + CNT_W'(1);
    end

    if (rd_vld_q) begin
      first_d = 1'b0;
      if (first_q) begin
        lo_d  = v;
        hi_d  = v;
        sum_d = {{(SUM_W-SW){v[SW-1]}}, v};
      end else begin
        if (v < lo_q) lo_d = v;
        if (v > hi_q) hi_d = v;
        sum_d = sum_q + {{(SUM_W-SW){v[SW-1]}}, v};
      end
    end

    if ((state_q == wts_pkg::ST_AVG_W) && div_status.done) begin
      avg_d = sum_q[SUM_W-1] ? (SW'(0) - quo_lo) : quo_lo;
    end
    if ((state_q == wts_pkg::ST_RNG) && (diff_rng != '0)) begin
      range_d = diff_rng;
    end
    if ((state_q == wts_pkg::ST_ZDIV_W) && div_status.done) begin
      // A zero range falls back to a tenth of |min|, then to 1.0.
      range_d = (div_quo == '0) ? RW'(wts_pkg::ONE_Q16) : div_quo[RW-1:0];
    end
    if ((state_q == wts_pkg::ST_MAR_W) && div_status.done) begin
      margin_d = quo_lo;
    end

    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wts_pkg::ST_IDLE;
      wr_idx_q    <= '0;
      fill_q      <= '0;
      iss_q       <= '0;
      rd_vld_q    <= 1'b0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_idx_q    <= wr_idx_d;
      fill_q      <= fill_d;
      iss_q       <= iss_d;
      rd_vld_q    <= rd_en;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    sum_q    <= sum_d;
    avg_q    <= avg_d;
    range_q  <= range_d;
    margin_q <= margin_d;
  end

  assign cnt_ext = 32'(fill_q);

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      window_min_o     <= lo_q;
      window_max_o     <= hi_q;
      lower_bound_o    <= {{(BW-SW){lo_q[SW-1]}}, lo_q} - {{(BW-SW){1'b0}}, margin_q};
      upper_bound_o    <= {{(BW-SW){hi_q[SW-1]}}, hi_q} + {{(BW-SW){1'b0}}, margin_q};
      window_average_o <= avg_q;
      sample_count_o   <= cnt_ext[wts_pkg::COUNT_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;

`include "windowed_trend_statistics_assert.svh"

  // Until the window is full, the write position equals the fill count.
  `WTS_ASSERT_IMPL(a_wr_tracks_fill, clk_i, rst_ni,
    fill_q != CNT_W'(WINDOW_DEPTH), CNT_W'(wr_idx_q) == fill_q)
  // Work on an item never starts with an empty window.
  `WTS_ASSERT_IMPL(a_fill_nonzero, clk_i, rst_ni,
    state_q != wts_pkg::ST_IDLE, fill_q != '0)
  // The divider only runs while the sequencer waits for it.
  `WTS_ASSERT_IMPL(a_div_owned, clk_i, rst_ni, div_status.busy,
    state_q == wts_pkg::ST_AVG_W || state_q == wts_pkg::ST_ZDIV_W ||
    state_q == wts_pkg::ST_MAR_W)
  // An accepted beat starts a scan from the first entry.
  `WTS_ASSERT_NEXT(a_accept_scan, clk_i, rst_ni, accept,
    state_q == wts_pkg::ST_SCAN && iss_q == '0 && first_q)
  // A new result appears only from the final sequencer state.
  `WTS_ASSERT_IMPL(a_out_source, clk_i, rst_ni, $rose(out_valid_q),
    $past(state_q == wts_pkg::ST_DONE))

endmodule

`default_nettype wire
